@@ rtl/greedy_change_dispenser_assert.svh @@
// Assertion macros for the checker file of the change dispenser.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef GREEDY_CHANGE_DISPENSER_ASSERT_SVH
`define GREEDY_CHANGE_DISPENSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCHG_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("greedy change dispenser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GCHG_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("greedy change dispenser: next-cycle check failed");

`endif

@@ rtl/gchg_pkg.sv @@
`default_nettype none

package gchg_pkg;

   // Field widths of the request and response channels.
   localparam int AMT_W  = 31;
   localparam int VAL_W  = 16;
   localparam int STK_W  = 16;
   localparam int IDX_W  = 4;
   localparam int PROD_W = VAL_W + STK_W;

   // Configuration port.
   localparam int CFG_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_SLOTS = 1'b0;
   localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd11;

   // No dispense ever produces more responses than this.
   localparam int RESULT_CAP = 16;

   // Request command codes.
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_DISPENSE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;
      logic             tbl_load;
      logic             fetch;
      logic             div_start;
      logic             clamp;
      logic             mul;
      logic             sub;
      logic             emit_ack;
      logic             emit_slot;
      logic             last;
      logic [IDX_W-1:0] slot;
   } gchg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic val_zero;
      logic out_free;
   } gchg_sts_type;

endpackage

`default_nettype wire

@@ rtl/gchg_div.sv @@
`default_nettype none

module gchg_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [gchg_pkg::AMT_W-1:0] dividend,
   input  wire logic [gchg_pkg::VAL_W-1:0] divisor,
   output logic                            done,
   output logic [gchg_pkg::AMT_W-1:0]      quotient
);
   import gchg_pkg::*;

   localparam int CNT_W = $clog2(AMT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AMT_W-1:0]  quot_ff, quot_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W:0]    rem_shift;
   logic [VAL_W:0]    diff;
   logic              ge;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[AMT_W-1]};
      diff      = rem_shift - {1'b0, divisor};
      ge        = (rem_shift >= {1'b0, divisor});
      busy_in   = busy_ff;
      done_in   = busy_ff && (cnt_ff == '0);
      cnt_in    = cnt_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(AMT_W - 1);
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[AMT_W-2:0], ge};
         rem_in  = ge ? diff[VAL_W-1:0] : rem_shift[VAL_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ rtl/gchg_dp.sv @@
`default_nettype none

module gchg_dp #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gchg_pkg::gchg_cmd_type     cmd,
   output gchg_pkg::gchg_sts_type          sts,
   input  wire logic [gchg_pkg::IDX_W-1:0] req_slot_index,
   input  wire logic [gchg_pkg::VAL_W-1:0] req_face_value,
   input  wire logic [gchg_pkg::STK_W-1:0] req_stock_in,
   input  wire logic [gchg_pkg::AMT_W-1:0] req_amount_cents,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [gchg_pkg::IDX_W-1:0]      rsp_slot_out,
   output logic [gchg_pkg::STK_W-1:0]      rsp_quantity,
   output logic [gchg_pkg::AMT_W-1:0]      rsp_shortfall,
   output logic                            rsp_last
);
   import gchg_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic [VAL_W-1:0]  value_ff [MAX_SLOTS];
   logic [STK_W-1:0]  stock_ff [MAX_SLOTS];
   logic [SLOT_W-1:0] load_idx;
   logic [SLOT_W-1:0] walk_idx;
   logic              load_hit;

   logic [IDX_W-1:0]  slot_ack_ff;
   logic [AMT_W-1:0]  amount_ff, amount_in;
   logic [VAL_W-1:0]  val_ff;
   logic [STK_W-1:0]  stk_ff;
   logic [STK_W-1:0]  qty_ff, qty_in;
   logic [PROD_W-1:0] prod_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_slot_ff;
   logic [STK_W-1:0]  rsp_qty_ff;
   logic [AMT_W-1:0]  rsp_short_ff;
   logic              rsp_last_ff;

   logic              div_done;
   logic [AMT_W-1:0]  quotient;

   // Table addressing; a load beyond the table leaves it untouched.
   assign load_idx = SLOT_W'(req_slot_index);
   assign walk_idx = SLOT_W'(cmd.slot);
   assign load_hit = cmd.tbl_load && (int'(req_slot_index) < MAX_SLOTS);

   // Denomination table, cleared at reset, written by loads and by stock updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            value_ff[i] <= '0;
            stock_ff[i] <= '0;
         end
      end else if (load_hit) begin
         value_ff[load_idx] <= req_face_value;
         stock_ff[load_idx] <= req_stock_in;
      end else if (cmd.sub) begin
         stock_ff[walk_idx] <= stk_ff - qty_ff;
      end
   end

   // Serial divider for the greedy quotient.
   gchg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (amount_ff),
      .divisor  (val_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Greedy quantity limited by stock, and the remaining amount.
   always_comb begin
      if (val_ff == '0) begin
         qty_in = '0;
      end else if (quotient > AMT_W'(stk_ff)) begin
         qty_in = stk_ff;
      end else begin
         qty_in = quotient[STK_W-1:0];
      end
      amount_in = amount_ff - prod_ff[AMT_W-1:0];
   end

   // Working registers of the slot walk.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         amount_ff   <= req_amount_cents;
         slot_ack_ff <= req_slot_index;
      end else if (cmd.sub) begin
         amount_ff <= amount_in;
      end
      if (cmd.fetch) begin
         val_ff <= value_ff[walk_idx];
         stk_ff <= stock_ff[walk_idx];
      end
      if (cmd.clamp) begin
         qty_ff <= qty_in;
      end
      if (cmd.mul) begin
         prod_ff <= val_ff * qty_ff;
      end
   end

   // Response register: a new response may load in the cycle the old one is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_ack || cmd.emit_slot) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ack) begin
         rsp_slot_ff  <= slot_ack_ff;
         rsp_qty_ff   <= '0;
         rsp_short_ff <= '0;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_slot) begin
         rsp_slot_ff  <= cmd.slot;
         rsp_qty_ff   <= qty_ff;
         rsp_short_ff <= cmd.last ? amount_ff : '0;
         rsp_last_ff  <= cmd.last;
      end
   end

   // Status back to the controller.
   assign sts.div_done = div_done;
   assign sts.val_zero = (val_ff == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_quantity  = rsp_qty_ff;
   assign rsp_shortfall = rsp_short_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/gchg_ctrl.sv @@
`default_nettype none

module gchg_ctrl #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_cmd,
   output logic                            req_ready,
   input  wire logic [gchg_pkg::CFG_W-1:0] slots_in_use,
   output gchg_pkg::gchg_cmd_type          cmd,
   input  wire gchg_pkg::gchg_sts_type     sts
);
   import gchg_pkg::*;

   localparam int WALK_MAX = (MAX_SLOTS < RESULT_CAP) ? MAX_SLOTS : RESULT_CAP;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] S_ACK   = 4'd1;
   localparam logic [ST_W-1:0] S_FETCH = 4'd2;
   localparam logic [ST_W-1:0] S_DIVGO = 4'd3;
   localparam logic [ST_W-1:0] S_DIV   = 4'd4;
   localparam logic [ST_W-1:0] S_CLAMP = 4'd5;
   localparam logic [ST_W-1:0] S_MUL   = 4'd6;
   localparam logic [ST_W-1:0] S_SUB   = 4'd7;
   localparam logic [ST_W-1:0] S_EMIT  = 4'd8;

   logic [ST_W-1:0]  state_ff, state_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CFG_W-1:0] walk_n;
   logic [IDX_W-1:0] walk_last;
   logic             accept;

   // Number of slots walked: at least one, at most the table and the response cap.
   always_comb begin
      if (slots_in_use == '0) begin
         walk_n = CFG_W'(1);
      end else if (slots_in_use > CFG_W'(WALK_MAX)) begin
         walk_n = CFG_W'(WALK_MAX);
      end else begin
         walk_n = slots_in_use;
      end
      walk_last = IDX_W'(walk_n - CFG_W'(1));
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Sequencer: per slot fetch, divide if nonzero, clamp, multiply, subtract, emit.
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      cmd.slot = slot_ff;
      cmd.last = (slot_ff == walk_last);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_cmd == CMD_LOAD) begin
                  cmd.tbl_load = 1'b1;
                  state_in     = S_ACK;
               end else begin
                  slot_in  = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_ACK: begin
            if (sts.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_DIVGO;
         end
         S_DIVGO: begin
            if (sts.val_zero) begin
               state_in = S_CLAMP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUB;
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_slot = 1'b1;
               if (slot_ff == walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/greedy_change_dispenser.sv @@
// Channel    Direction  Handshake                Payload
// req        in         req_valid / req_ready    cmd, slot_index, face_value, stock_in,
//                                                amount_cents
// rsp        out        rsp_valid / rsp_ready    slot_out, quantity, shortfall, last
// csr        in/out     psel, penable, pready    slots_in_use at byte addresses 0 to 3
//
// A load request writes the table at acceptance, then waits in an acknowledge state before the next request.
// A dispense request walks the slots one at a time; a slot with a nonzero value goes through
// the 31-step serial divider, and a slot whose value is zero skips it.
// One request is in flight at a time; req_ready is high only while the sequencer is idle.
// A stalled response holds the walk at the next emit; reset is synchronous, active high,
// and clears the table, the slot count (to 11) and all handshake state.
`default_nettype none

module greedy_change_dispenser #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [gchg_pkg::IDX_W-1:0]      req_slot_index,
   input  wire logic [gchg_pkg::VAL_W-1:0]      req_face_value,
   input  wire logic [gchg_pkg::STK_W-1:0]      req_stock_in,
   input  wire logic [gchg_pkg::AMT_W-1:0]      req_amount_cents,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [gchg_pkg::IDX_W-1:0]           rsp_slot_out,
   output logic [gchg_pkg::STK_W-1:0]           rsp_quantity,
   output logic [gchg_pkg::AMT_W-1:0]           rsp_shortfall,
   output logic                                 rsp_last,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gchg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gchg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gchg_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import gchg_pkg::*;

   logic [CFG_W-1:0] slots_ff;
   logic             csr_write;
   gchg_cmd_type     cmd;
   gchg_sts_type     sts;

   // Configuration register, decoded by address bit 2; writes with that bit set are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_SLOTS)) begin
         slots_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // Read data for the register at addresses 0 to 3, zero at addresses 4 to 7.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_SLOTS) begin
         csr_prdata = CSR_DATA_W'(slots_ff);
      end
   end

   // Controller.
   gchg_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_cmd      (req_cmd),
      .req_ready    (req_ready),
      .slots_in_use (slots_ff),
      .cmd          (cmd),
      .sts          (sts)
   );

   // Datapath.
   gchg_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_slot_index   (req_slot_index),
      .req_face_value   (req_face_value),
      .req_stock_in     (req_stock_in),
      .req_amount_cents (req_amount_cents),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_quantity     (rsp_quantity),
      .rsp_shortfall    (rsp_shortfall),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

@@ rtl/gchg_checker.sv @@
`default_nettype none
`include "greedy_change_dispenser_assert.svh"

module gchg_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [gchg_pkg::IDX_W-1:0] rsp_slot_out,
   input  wire logic [gchg_pkg::STK_W-1:0] rsp_quantity,
   input  wire logic [gchg_pkg::AMT_W-1:0] rsp_shortfall,
   input  wire logic                       rsp_last
);
   import gchg_pkg::*;

   // A stalled response keeps its contents.
   `GCHG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_slot_out) && $stable(rsp_quantity) &&
      $stable(rsp_shortfall) && $stable(rsp_last))

   // Only the last response of a request carries a shortfall.
   `GCHG_ASSERT_SAME(a_short_last, rsp_valid && !rsp_last, rsp_shortfall == '0)

   // One request at a time: the block is busy right after taking one.
   `GCHG_ASSERT_NEXT(a_one_busy, req_valid && req_ready, !req_ready)

   // While a dispense still has slots to walk, no new request is taken.
   `GCHG_ASSERT_SAME(a_walk_busy, rsp_valid && !rsp_last, !req_ready)

endmodule

bind greedy_change_dispenser gchg_checker u_checker (.*);

`default_nettype wire

@@ sim/change_checker.sv @@
module change_checker #(
   parameter int MAX_SLOTS = 16,
   parameter logic [gchg_pkg::CSR_ADDR_W-1:0] SLOTS_ADDR = '0
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [gchg_pkg::IDX_W-1:0]      req_slot_index,
   input  wire logic [gchg_pkg::VAL_W-1:0]      req_face_value,
   input  wire logic [gchg_pkg::STK_W-1:0]      req_stock_in,
   input  wire logic [gchg_pkg::AMT_W-1:0]      req_amount_cents,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [gchg_pkg::IDX_W-1:0]      rsp_slot_out,
   input  wire logic [gchg_pkg::STK_W-1:0]      rsp_quantity,
   input  wire logic [gchg_pkg::AMT_W-1:0]      rsp_shortfall,
   input  wire logic                            rsp_last,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gchg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gchg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [gchg_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   checked_count,
   output int                                   limited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import gchg_pkg::*;

   // One response of the dispenser.
   typedef struct packed {
      logic [IDX_W-1:0] slot;
      logic [STK_W-1:0] qty;
      logic [AMT_W-1:0] shortfall;
      logic             last;
   } payout_type;

   logic [VAL_W-1:0] face_tbl [MAX_SLOTS];
   logic [STK_W-1:0] stock_tbl [MAX_SLOTS];
   logic [CFG_W-1:0] walk_cfg;
   payout_type       expected_payouts [$];

   // Number of slots a dispense walks for the current register value.
   function automatic int walk_length();
      int n;
      n = walk_cfg;
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_SLOTS) begin
         n = MAX_SLOTS;
      end
      if (n > RESULT_CAP) begin
         n = RESULT_CAP;
      end
      return n;
   endfunction

   // A load writes one slot and is acknowledged with a single response.
   task automatic predict_load(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] face,
                               input logic [STK_W-1:0] stock);
      if (idx < MAX_SLOTS) begin
         face_tbl[idx]  = face;
         stock_tbl[idx] = stock;
      end
      expected_payouts.push_back('{slot: idx, qty: '0, shortfall: '0, last: 1'b1});
   endtask

   // Greedy walk over the slots in use, taking as many pieces as stock allows.
   task automatic predict_change(input logic [AMT_W-1:0] amount);
      logic [AMT_W-1:0] remain;
      logic [31:0]      take;
      int               n;
      int               d;
      remain = amount;
      n = walk_length();
      for (d = 0; d < n; d++) begin
         take = '0;
         if (face_tbl[d] != '0) begin
            take = 32'(remain) / 32'(face_tbl[d]);
            if (take > 32'(stock_tbl[d])) begin
               take = 32'(stock_tbl[d]);
               limited_count++;
            end
            stock_tbl[d] = stock_tbl[d] - take[STK_W-1:0];
            remain = AMT_W'(32'(remain) - 32'(face_tbl[d]) * take);
         end
         expected_payouts.push_back('{slot: IDX_W'(d), qty: take[STK_W-1:0],
                                      shortfall: (d == n - 1) ? remain : '0,
                                      last: (d == n - 1)});
      end
   endtask

   task automatic compare_field(input string name, input logic [IDX_W-1:0] slot,
                                input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch at slot %0d: expected %0d, actual %0d",
                  $time, name, slot, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      payout_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            face_tbl[i]  = '0;
            stock_tbl[i] = '0;
         end
         walk_cfg = SLOTS_RESET;
         expected_payouts.delete();
         fail_count    = 0;
         checked_count = 0;
         limited_count = 0;
      end else begin
         // Register traffic: track writes, check reads of the slot count.
         if (csr_psel && csr_penable && csr_pready && csr_paddr == SLOTS_ADDR) begin
            if (csr_pwrite) begin
               walk_cfg = csr_pwdata[CFG_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(walk_cfg)) begin
               $display("%0t: slot count readback mismatch: expected %0d, actual %0d",
                        $time, walk_cfg, csr_prdata);
               fail_count++;
            end
         end

         // Accepted request: work out every response it causes.
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD) begin
               predict_load(req_slot_index, req_face_value, req_stock_in);
            end else begin
               predict_change(req_amount_cents);
            end
         end

         // Accepted response: compare with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_payouts.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual slot %0d qty %0d",
                        $time, rsp_slot_out, rsp_quantity);
               fail_count++;
            end else begin
               want = expected_payouts.pop_front();
               compare_field("slot", want.slot, 32'(want.slot), 32'(rsp_slot_out));
               compare_field("quantity", want.slot, 32'(want.qty), 32'(rsp_quantity));
               compare_field("shortfall", want.slot, 32'(want.shortfall),
                             32'(rsp_shortfall));
               compare_field("last", want.slot, 32'(want.last), 32'(rsp_last));
               checked_count++;
            end
         end
      end
      pending = expected_payouts.size();
   end

endmodule

@@ sim/tb_greedy_change_dispenser.sv @@
module tb_greedy_change_dispenser;
   timeunit 1ns;
   timeprecision 1ps;

   import gchg_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int LIMIT_CYCLES   = 1_200_000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MIXED_PER_SET  = 28;
   localparam logic [CSR_ADDR_W-1:0] SLOTS_ADDR = CSR_ADDR_W'(CSR_IDX_SLOTS) << 2;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [IDX_W-1:0]      req_slot_index;
   logic [VAL_W-1:0]      req_face_value;
   logic [STK_W-1:0]      req_stock_in;
   logic [AMT_W-1:0]      req_amount_cents;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_slot_out;
   logic [STK_W-1:0]      rsp_quantity;
   logic [AMT_W-1:0]      rsp_shortfall;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int checked_count;
   int limited_count;

   int   gap_pct = 0;
   int   stall_pct = 0;
   logic holdoff_go = 1'b0;
   int   load_count = 0;
   int   dispense_count = 0;
   int   cycle_count = 0;

   greedy_change_dispenser dut (.*);

   change_checker #(.SLOTS_ADDR(SLOTS_ADDR)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_greedy_change_dispenser NOT OK");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_go) begin
            holdoff_go = 1'b0;
            rsp_ready  = 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request, with random gaps first; returns at the falling edge after acceptance.
   task automatic offer_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] face, input logic [STK_W-1:0] stock,
                                input logic [AMT_W-1:0] amount);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd          = cmd;
      req_slot_index   = idx;
      req_face_value   = face;
      req_stock_in     = stock;
      req_amount_cents = amount;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Fields that a command does not use carry random bits.
   task automatic load_slot(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] face,
                            input logic [STK_W-1:0] stock);
      offer_request(CMD_LOAD, idx, face, stock, AMT_W'($urandom));
      load_count++;
   endtask

   task automatic dispense(input logic [AMT_W-1:0] amount);
      offer_request(CMD_DISPENSE, IDX_W'($urandom), VAL_W'($urandom), STK_W'($urandom),
                    amount);
      dispense_count++;
   endtask

   // Stop offering and wait until every response has come back.
   task automatic wait_idle();
      req_valid = 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(negedge clock);
   endtask

   // Setup then access phase; the register takes the value at the access edge.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [VAL_W-1:0] pick_face();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return VAL_W'($urandom);
         default: return VAL_W'($urandom_range(1, 1000));
      endcase
   endfunction

   function automatic logic [STK_W-1:0] pick_stock();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return STK_W'($urandom);
         default: return STK_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [AMT_W-1:0] pick_amount();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return AMT_W'($urandom);
         default: return AMT_W'($urandom_range(0, 100000));
      endcase
   endfunction

   // Fill all slots with values falling from largest to smallest, some left at zero.
   task automatic load_table();
      logic [VAL_W-1:0] face;
      int               i;
      face = ($urandom_range(0, 3) == 0) ? '1 : VAL_W'($urandom_range(200, 20000));
      for (i = 0; i < 16; i++) begin
         load_slot(IDX_W'(i), ($urandom_range(0, 9) == 0) ? '0 : face, pick_stock());
         face = face / VAL_W'($urandom_range(1, 3));
      end
   endtask

   initial begin
      int cfg_list [8];
      int set_idx;
      int k;
      logic [CFG_W-1:0] cfg;

      cfg_list         = '{16, 1, 31, 0, 11, 17, 8, 0};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_LOAD;
      req_slot_index   = '0;
      req_face_value   = '0;
      req_stock_in     = '0;
      req_amount_cents = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table at the reset slot count, then field extremes.
      dispense(AMT_W'(123));
      load_slot(4'd0, '1, '1);
      load_slot(4'd1, VAL_W'(1), '1);
      load_slot(4'd15, '0, '1);
      load_slot(4'd2, VAL_W'(100), '0);
      dispense('1);
      dispense('0);
      load_slot(4'd1, VAL_W'(1), STK_W'(3));
      load_slot(4'd0, VAL_W'(500), STK_W'(2));
      dispense(AMT_W'(1799));

      // A slot count of zero still walks slot zero.
      wait_idle();
      csr_access(1'b1, SLOTS_ADDR, '0);
      csr_access(1'b0, SLOTS_ADDR, '0);
      dispense(AMT_W'(777));

      // The largest slot count saturates to the table size; the spare address is ignored.
      wait_idle();
      csr_access(1'b1, SLOTS_ADDR, CSR_DATA_W'(31));
      csr_access(1'b1, SPARE_ADDR, $urandom);
      csr_access(1'b0, SLOTS_ADDR, '0);
      dispense(AMT_W'(65535));
      load_slot(4'd7, VAL_W'(12345), STK_W'(9));
      dispense(AMT_W'(100000));

      // Random sets: new slot count, fresh table, then a mix of loads and dispenses.
      for (set_idx = 0; set_idx < 8; set_idx++) begin
         wait_idle();
         cfg = (set_idx == 7) ? CFG_W'($urandom) : CFG_W'(cfg_list[set_idx]);
         csr_access(1'b1, SLOTS_ADDR, CSR_DATA_W'(cfg));
         csr_access(1'b0, SLOTS_ADDR, '0);
         case (set_idx % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 63; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 63; end
            default: begin gap_pct = 20; stall_pct = 20; end
         endcase
         // Hold the response side off so the block fills up and stalls requests.
         if (set_idx == 2) begin
            holdoff_go = 1'b1;
         end
         load_table();
         for (k = 0; k < MIXED_PER_SET; k++) begin
            if (set_idx == 1 && k == MIXED_PER_SET / 2) begin
               wait_idle();
            end
            if ($urandom_range(0, 9) < 3) begin
               load_slot(IDX_W'($urandom), pick_face(), pick_stock());
            end else begin
               dispense(pick_amount());
            end
         end
      end

      // Drain and give the verdict.
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d loads and %0d dispenses over 11 slot-count settings,",
               load_count, dispense_count);
      $display("with %0d responses checked and %0d takes limited by stock.",
               checked_count, limited_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_greedy_change_dispenser OK");
      end else begin
         $display("tb_greedy_change_dispenser NOT OK");
      end
      $finish;
   end

endmodule

@@ greedy_change_dispenser.f @@
+incdir+rtl
rtl/gchg_pkg.sv
rtl/gchg_div.sv
rtl/gchg_dp.sv
rtl/gchg_ctrl.sv
rtl/greedy_change_dispenser.sv
rtl/gchg_checker.sv
sim/change_checker.sv
sim/tb_greedy_change_dispenser.sv
